// File: hdl/tnva_pkg.sv
// tnva_pkg: shared types and constants of the nodal volume accumulator
// no dependencies
`timescale 1ns / 1ps

package tnva_pkg;

  localparam int SUM_BITS = 60;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ELEM = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

endpackage

// File: hdl/tnva_vol.sv
// tnva_vol: pipelined absolute triple product of one tetrahedron (6x volume)
// depends on tnva_pkg
`timescale 1ns / 1ps

module tnva_vol import tnva_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] x_i [4],
  input  logic signed [COORD_BITS-1:0] y_i [4],
  input  logic signed [COORD_BITS-1:0] z_i [4],
  output logic                         done_o,
  output logic [SUM_BITS-1:0]          mag_o,
  output logic                         clamp_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int TW = CW + DW;
  localparam int SW = TW + 2;
  localparam int XW = (SW > SUM_BITS) ? SW : SUM_BITS + 1;

  logic [4:0] vld_q;

  logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, dx_q, dy_q, dz_q;
  logic signed [DW-1:0] dx2_q, dy2_q, dz2_q, dx3_q, dy3_q, dz3_q;
  logic signed [PW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic signed [TW-1:0] ex_q, ey_q, ez_q;
  logic signed [SW-1:0] t_d;
  logic [SW-1:0]        abs_d;
  logic [XW-1:0]        magx_d;
  logic [SUM_BITS-1:0]  mag_q;
  logic                 clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  // edge vectors from the first corner
  always_ff @(posedge clk_i) begin
    ax_q <= DW'(x_i[1]) - DW'(x_i[0]);
    ay_q <= DW'(y_i[1]) - DW'(y_i[0]);
    az_q <= DW'(z_i[1]) - DW'(z_i[0]);
    bx_q <= DW'(x_i[2]) - DW'(x_i[0]);
    by_q <= DW'(y_i[2]) - DW'(y_i[0]);
    bz_q <= DW'(z_i[2]) - DW'(z_i[0]);
    dx_q <= DW'(x_i[3]) - DW'(x_i[0]);
    dy_q <= DW'(y_i[3]) - DW'(y_i[0]);
    dz_q <= DW'(z_i[3]) - DW'(z_i[0]);
  end

  // cross product terms
  always_ff @(posedge clk_i) begin
    m0_q  <= PW'(ay_q) * PW'(bz_q);
    m1_q  <= PW'(az_q) * PW'(by_q);
    m2_q  <= PW'(az_q) * PW'(bx_q);
    m3_q  <= PW'(ax_q) * PW'(bz_q);
    m4_q  <= PW'(ax_q) * PW'(by_q);
    m5_q  <= PW'(ay_q) * PW'(bx_q);
    dx2_q <= dx_q;
    dy2_q <= dy_q;
    dz2_q <= dz_q;
  end

  always_ff @(posedge clk_i) begin
    cx_q  <= CW'(m0_q) - CW'(m1_q);
    cy_q  <= CW'(m2_q) - CW'(m3_q);
    cz_q  <= CW'(m4_q) - CW'(m5_q);
    dx3_q <= dx2_q;
    dy3_q <= dy2_q;
    dz3_q <= dz2_q;
  end

  // dot product terms
  always_ff @(posedge clk_i) begin
    ex_q <= TW'(cx_q) * TW'(dx3_q);
    ey_q <= TW'(cy_q) * TW'(dy3_q);
    ez_q <= TW'(cz_q) * TW'(dz3_q);
  end

  always_comb begin
    t_d    = SW'(ex_q) + SW'(ey_q) + SW'(ez_q);
    abs_d  = t_d[SW-1] ? SW'(-t_d) : SW'(t_d);
    magx_d = XW'(abs_d);
  end

  always_ff @(posedge clk_i) begin
    if (magx_d > XW'(SUM_MAX)) begin
      mag_q   <= SUM_MAX;
      clamp_q <= 1'b1;
    end else begin
      mag_q   <= magx_d[SUM_BITS-1:0];
      clamp_q <= 1'b0;
    end
  end

  assign done_o  = vld_q[4];
  assign mag_o   = mag_q;
  assign clamp_o = clamp_q;

endmodule

// File: hdl/tet_nodal_volume_accumulator.sv
// tet_nodal_volume_accumulator: lumps tetrahedron volumes onto mesh nodes
// depends on tnva_pkg and tnva_vol
`timescale 1ns / 1ps

// usage
//   input channel (in_valid_i/in_ready_o) carries one command beat:
//   load stores a node's coordinates and zeroes its sum, element computes
//   six times the volume of a tetrahedron and adds it to its four corners,
//   read returns a node's sum (24 times its lumped volume)
//   output channel (out_valid_o/out_ready_i) returns one beat per command
// sequencing
//   one command at a time; element makes four coordinate reads, a
//   5 stage product pipeline and four read-modify-write passes over the
//   single ported accumulator memory
//   out-of-range or unused commands go straight to the done state
// reset
//   after reset a clearing pass zeroes every accumulator and flag,
//   one entry per cycle; in_ready_o stays low meanwhile
// stall
//   a finished result sits in the output register; a new command is taken
//   while it waits, but its own result holds until the register is free
module tet_nodal_volume_accumulator import tnva_pkg::*; #(
  parameter int NODE_COUNT = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [11:0]         node_index_i,
  input  logic signed [15:0]  coord_x_i,
  input  logic signed [15:0]  coord_y_i,
  input  logic signed [15:0]  coord_z_i,
  input  logic [11:0]         first_node_i,
  input  logic [11:0]         second_node_i,
  input  logic [11:0]         third_node_i,
  input  logic [11:0]         fourth_node_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SUM_BITS-1:0] value_o,
  output logic                saturated_o
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int CB = COORD_BITS;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_RDWAIT = 10'b00_0000_0100,
    S_CRD    = 10'b00_0000_1000,
    S_CAP    = 10'b00_0001_0000,
    S_VGO    = 10'b00_0010_0000,
    S_VWAIT  = 10'b00_0100_0000,
    S_ACCRD  = 10'b00_1000_0000,
    S_ACCWR  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  function automatic logic [AW-1:0] to_addr(input logic [11:0] i);
    logic [31:0] w;
    w = {20'b0, i};
    return w[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [11:0] i);
    return {20'b0, i} < 32'(NODE_COUNT);
  endfunction

  function automatic logic [CB-1:0] low_coord(input logic [15:0] c);
    logic [31:0] w;
    w = {16'b0, c};
    return w[CB-1:0];
  endfunction

  state_e state_q, state_d;

  logic [AW-1:0]       clr_q;
  logic [1:0]          k_q;
  logic [11:0]         c_q [4];
  logic                rd_pend_q;
  logic [1:0]          rd_idx_q;
  logic signed [CB-1:0] px_q [4];
  logic signed [CB-1:0] py_q [4];
  logic signed [CB-1:0] pz_q [4];
  logic [SUM_BITS-1:0] mag_q;
  logic [SUM_BITS-1:0] res_val_q;
  logic                res_sat_q;
  logic                out_valid_q;
  logic [SUM_BITS-1:0] out_val_q;
  logic                out_sat_q;

  // accumulator memory: {flag, sum}
  logic [SUM_BITS:0]   sum_mem [NODE_COUNT];
  logic                sum_we;
  logic [AW-1:0]       sum_addr;
  logic [SUM_BITS:0]   sum_wd;
  logic [SUM_BITS:0]   sum_rd_q;

  // coordinate memory: {z, y, x}
  logic [3*CB-1:0]     crd_mem [NODE_COUNT];
  logic                crd_we;
  logic [AW-1:0]       crd_addr;
  logic [3*CB-1:0]     crd_wd;
  logic [3*CB-1:0]     crd_rd_q;

  logic                in_acc;
  logic                all_in;
  logic [SUM_BITS:0]   add_d;
  logic                new_flag;
  logic                out_free;
  logic                vol_done;
  logic [SUM_BITS-1:0] vol_mag;
  logic                vol_clamp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign all_in     = in_range(first_node_i) && in_range(second_node_i) &&
                      in_range(third_node_i) && in_range(fourth_node_i);
  assign out_free   = !out_valid_q || out_ready_i;

  // saturating add of the element magnitude into the stored sum
  assign add_d    = {1'b0, sum_rd_q[SUM_BITS-1:0]} + {1'b0, mag_q};
  assign new_flag = sum_rd_q[SUM_BITS] || add_d[SUM_BITS];

  always_comb begin
    sum_we   = 1'b0;
    sum_addr = to_addr(c_q[k_q]);
    sum_wd   = '0;
    crd_we   = 1'b0;
    crd_addr = to_addr(c_q[k_q]);
    crd_wd   = {low_coord(coord_z_i), low_coord(coord_y_i), low_coord(coord_x_i)};
    case (state_q)
      S_CLEAR: begin
        sum_we   = 1'b1;
        sum_addr = clr_q;
      end
      S_IDLE: begin
        sum_addr = to_addr(node_index_i);
        crd_addr = to_addr(node_index_i);
        if (in_acc && cmd_i == CMD_LOAD && in_range(node_index_i)) begin
          sum_we = 1'b1;
          crd_we = 1'b1;
        end
      end
      S_ACCWR: begin
        sum_we = 1'b1;
        sum_wd = {new_flag, add_d[SUM_BITS] ? SUM_MAX : add_d[SUM_BITS-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wd;
    end else begin
      sum_rd_q <= sum_mem[sum_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (crd_we) begin
      crd_mem[crd_addr] <= crd_wd;
    end else begin
      crd_rd_q <= crd_mem[crd_addr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(NODE_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(cmd_i))
            CMD_READ: state_d = in_range(node_index_i) ? S_RDWAIT : S_DONE;
            CMD_ELEM: state_d = all_in ? S_CRD : S_DONE;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_RDWAIT: state_d = S_DONE;
      S_CRD:    if (k_q == 2'd3) state_d = S_CAP;
      S_CAP:    state_d = S_VGO;
      S_VGO:    state_d = S_VWAIT;
      S_VWAIT:  if (vol_done) state_d = S_ACCRD;
      S_ACCRD:  state_d = S_ACCWR;
      S_ACCWR:  state_d = (k_q == 2'd3) ? S_DONE : S_ACCRD;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == S_CRD);
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      case (state_q)
        S_IDLE:  k_q <= '0;
        S_CRD:   k_q <= k_q + 1'b1;
        S_VWAIT: k_q <= '0;
        S_ACCWR: k_q <= k_q + 1'b1;
        default: begin
        end
      endcase
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      c_q[0]    <= first_node_i;
      c_q[1]    <= second_node_i;
      c_q[2]    <= third_node_i;
      c_q[3]    <= fourth_node_i;
      res_val_q <= '0;
      res_sat_q <= 1'b0;
    end
    if (state_q == S_CRD) rd_idx_q <= k_q;
    if (rd_pend_q) begin
      px_q[rd_idx_q] <= crd_rd_q[CB-1:0];
      py_q[rd_idx_q] <= crd_rd_q[2*CB-1:CB];
      pz_q[rd_idx_q] <= crd_rd_q[3*CB-1:2*CB];
    end
    if (state_q == S_RDWAIT) begin
      res_val_q <= sum_rd_q[SUM_BITS-1:0];
      res_sat_q <= sum_rd_q[SUM_BITS];
    end
    if (state_q == S_VWAIT && vol_done) begin
      mag_q     <= vol_mag;
      res_sat_q <= vol_clamp;
    end
    if (state_q == S_ACCWR) begin
      res_val_q <= mag_q;
      res_sat_q <= res_sat_q || new_flag;
    end
    if (state_q == S_DONE && out_free) begin
      out_val_q <= res_val_q;
      out_sat_q <= res_sat_q;
    end
  end

  tnva_vol #(
    .COORD_BITS(CB)
  ) u_vol (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_VGO),
    .x_i     (px_q),
    .y_i     (py_q),
    .z_i     (pz_q),
    .done_o  (vol_done),
    .mag_o   (vol_mag),
    .clamp_o (vol_clamp)
  );

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign saturated_o = out_sat_q;

  // product pipeline only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vol_done |-> state_q == S_VWAIT)
    else $error("volume result outside wait state");

  // a saturated accumulator always holds the ceiling value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCWR && sum_wd[SUM_BITS]) |-> sum_wd[SUM_BITS-1:0] == SUM_MAX)
    else $error("flagged accumulator below ceiling");

  // no command taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o && !out_valid_o)
    else $error("activity during clearing pass");

endmodule
